[hdl/kclc_pkg.sv]
// Shared definitions for the keypad code lock controller: code length,
// key and register codes, reset values and the entry-buffer control type.
// No dependencies; imported by kclc_entry, keypad_code_lock_controller and tb.
package kclc_pkg;

   // Code length and the widths that follow from it.
   localparam int CODE_DIGITS = 8;
   localparam int IDX_W       = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
   localparam int CNT_W       = 4;
   localparam int DIGIT_W     = 4;

   // Entry count saturates one above the code length, limited by the 4-bit field.
   localparam logic [CNT_W-1:0] ENTRY_CAP =
      CNT_W'((CODE_DIGITS < 15) ? CODE_DIGITS + 1 : 15);

   localparam logic [DIGIT_W-1:0] BLANK_ENTRY   = 4'hf;
   localparam logic [DIGIT_W-1:0] RESET_DIGIT   = 4'd8;
   localparam logic [2:0]         FAIL_MAX      = 3'd7;
   localparam logic [7:0]         HOLD_RESET    = 8'd20;
   localparam logic [2:0]         LOCKOUT_RESET = 3'd3;

   // Key codes.
   localparam logic [3:0] KEY_0       = 4'd0;
   localparam logic [3:0] KEY_9       = 4'd9;
   localparam logic [3:0] KEY_ENTER   = 4'd10;
   localparam logic [3:0] KEY_B       = 4'd11;
   localparam logic [3:0] KEY_CANCEL  = 4'd12;
   localparam logic [3:0] KEY_CHANGE  = 4'd13;
   localparam logic [3:0] KEY_CONFIRM = 4'd14;
   localparam logic [3:0] KEY_F       = 4'd15;

   // Item kinds carried on the input tuser.
   localparam logic ACTION_KEY  = 1'b0;
   localparam logic ACTION_TICK = 1'b1;

   // Configuration register indexes.
   localparam logic CSR_HOLD    = 1'b0;
   localparam logic CSR_LOCKOUT = 1'b1;

   typedef logic [CODE_DIGITS-1:0][DIGIT_W-1:0] code_type;

   typedef struct packed {
      logic                 append;
      logic                 clear;
      logic [DIGIT_W-1:0]   value;
   } entry_ctl_type;

endpackage

[hdl/kclc_entry.sv]
// Entry buffer of the keypad code lock: holds the keys typed so far, their
// saturating count, and compares the buffer with the stored code.
// Depends on kclc_pkg.
module kclc_entry
   import kclc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  entry_ctl_type     ctl,
   input  code_type          code,
   output logic [CNT_W-1:0]  count_in,
   output logic [CNT_W-1:0]  count,
   output logic              match
);

   code_type          slot_ff, slot_in;
   logic [CNT_W-1:0]  count_ff;

   // Clear or append one key; the count keeps rising to its cap after the buffer fills.
   always_comb begin
      slot_in  = slot_ff;
      count_in = count_ff;
      if (ctl.clear) begin
         slot_in  = {CODE_DIGITS{BLANK_ENTRY}};
         count_in = '0;
      end else if (ctl.append) begin
         if (int'(count_ff) < CODE_DIGITS) begin
            slot_in[count_ff[IDX_W-1:0]] = ctl.value;
         end
         if (count_ff < ENTRY_CAP) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= {CODE_DIGITS{BLANK_ENTRY}};
         count_ff <= '0;
      end else begin
         slot_ff  <= slot_in;
         count_ff <= count_in;
      end
   end

   // A match needs exactly a full code's worth of keys, all equal to the code.
   assign match = (int'(count_ff) == CODE_DIGITS) && (slot_ff == code);
   assign count = count_ff;

endmodule

[hdl/keypad_code_lock_controller.sv]
// Keypad code lock controller: takes key and tick beats, updates the lock state
// in the cycle a beat is accepted and presents one result beat the cycle after.
// Throughput is one item per cycle while the receiver keeps taking results, set by the single
// output register, which accepts a new beat while its result is being taken.
// Reset is synchronous and active high; it restores the default code (all
// eights), clears the entry, counters and flags and loads the default registers.
module keypad_code_lock_controller
   import kclc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // Input stream.
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [3:0] key, [7:4] zero
   input  logic         req_tuser,   // [0] action: 0 key press, 1 timer tick
   // Result stream.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [15:0]  rsp_tdata,   // [0] unlocked, [1] alarm, [4:2] failures,
                                     // [8:5] entered, [9] changing, [10] locked_out
   // Configuration writes.
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [7:0]   csr_wdata
);

   logic              accept;
   logic [3:0]        key;
   entry_ctl_type     entry_ctl;
   logic [CNT_W-1:0]  count_in, count;
   logic              entry_match;

   logic [7:0]        hold_ff, hold_in;
   logic [2:0]        lockout_ff, lockout_in;
   code_type          code_ff, code_in;
   logic [2:0]        fail_ff, fail_in;
   logic              change_ff, change_in;
   logic [IDX_W-1:0]  cap_ff, cap_in;
   logic [IDX_W:0]    cap_next;
   logic              run_ff, run_in;
   logic [7:0]        rel_ff, rel_in;
   logic              open_ff, open_in;
   logic              alarm_ff, alarm_in;
   logic [2:0]        limit;
   logic              locked_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [15:0]       rsp_data_ff;

   assign accept     = req_tvalid && req_tready;
   assign key        = req_tdata[3:0];
   assign req_tready = !rsp_valid_ff || rsp_tready;

   kclc_entry u_entry (
      .clock    (clock),
      .reset    (reset),
      .ctl      (entry_ctl),
      .code     (code_ff),
      .count_in (count_in),
      .count    (count),
      .match    (entry_match)
   );

   // Configuration register writes.
   always_comb begin
      hold_in    = hold_ff;
      lockout_in = lockout_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_HOLD:    hold_in    = csr_wdata;
            CSR_LOCKOUT: lockout_in = csr_wdata[2:0];
            default:     ;
         endcase
      end
   end

   // A lockout value of zero behaves as one.
   assign limit    = (lockout_ff == 3'd0) ? 3'd1 : lockout_ff;
   assign cap_next = {1'b0, cap_ff} + 1'b1;

   // Key and tick decoding and the lock state update.
   always_comb begin
      entry_ctl       = '0;
      entry_ctl.value = key;
      code_in         = code_ff;
      fail_in         = fail_ff;
      change_in       = change_ff;
      cap_in          = cap_ff;
      run_in          = run_ff;
      rel_in          = rel_ff;
      open_in         = open_ff;
      alarm_in        = alarm_ff;
      if (accept) begin
         if (req_tuser == ACTION_TICK) begin
            if (run_ff) begin
               if (rel_ff < hold_ff) begin
                  rel_in = rel_ff + 1'b1;
               end else begin
                  run_in   = 1'b0;
                  rel_in   = '0;
                  open_in  = 1'b0;
                  alarm_in = 1'b0;
               end
            end
         end else begin
            unique case (key) inside
               [KEY_0:KEY_9]: begin
                  entry_ctl.append = 1'b1;
                  if (change_ff) begin
                     code_in[cap_ff] = key;
                     if (int'(cap_next) >= CODE_DIGITS) begin
                        cap_in    = '0;
                        change_in = 1'b0;
                     end else begin
                        cap_in = cap_next[IDX_W-1:0];
                     end
                  end
               end
               KEY_B, KEY_F: begin
                  entry_ctl.append = 1'b1;
               end
               KEY_ENTER: begin
                  entry_ctl.clear = 1'b1;
                  run_in          = 1'b1;
                  rel_in          = '0;
                  if (entry_match) begin
                     open_in = 1'b1;
                     fail_in = '0;
                  end else begin
                     open_in  = 1'b0;
                     alarm_in = 1'b1;
                     if (fail_ff < FAIL_MAX) begin
                        fail_in = fail_ff + 1'b1;
                     end
                     // Once locked out the timer stops and the alarm stays latched.
                     if (fail_in >= limit) begin
                        run_in = 1'b0;
                     end
                  end
               end
               KEY_CANCEL: begin
                  entry_ctl.clear = 1'b1;
               end
               KEY_CHANGE: begin
                  entry_ctl.clear = 1'b1;
                  change_in       = 1'b1;
                  cap_in          = '0;
               end
               KEY_CONFIRM: begin
                  entry_ctl.clear = 1'b1;
                  change_in       = 1'b0;
                  cap_in          = '0;
                  run_in          = 1'b1;
                  rel_in          = '0;
               end
               default: ;
            endcase
         end
      end
   end

   assign locked_in    = (fail_in >= limit);
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);

   // Control and lock state.
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff      <= HOLD_RESET;
         lockout_ff   <= LOCKOUT_RESET;
         code_ff      <= {CODE_DIGITS{RESET_DIGIT}};
         fail_ff      <= '0;
         change_ff    <= 1'b0;
         cap_ff       <= '0;
         run_ff       <= 1'b0;
         rel_ff       <= '0;
         open_ff      <= 1'b0;
         alarm_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hold_ff      <= hold_in;
         lockout_ff   <= lockout_in;
         code_ff      <= code_in;
         fail_ff      <= fail_in;
         change_ff    <= change_in;
         cap_ff       <= cap_in;
         run_ff       <= run_in;
         rel_ff       <= rel_in;
         open_ff      <= open_in;
         alarm_ff     <= alarm_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result beat: the state after the accepted item.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= {5'b0, locked_in, change_in, count_in, fail_in, alarm_in, open_in};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Every accepted beat produces a result in the following cycle.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_tvalid)
      else $error("accepted beat produced no result");

   // The capture position only moves while a new code is being captured.
   a_capture_in_change: assert property (@(posedge clock) disable iff (reset)
      (cap_ff != '0) |-> change_ff)
      else $error("capture index set outside change mode");

   // A correct code opens the lock and clears the failure count.
   a_match_opens: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_tuser == ACTION_KEY) && (key == KEY_ENTER) && entry_match)
      |=> (open_ff && (fail_ff == 3'd0)))
      else $error("match did not open the lock");

   // The final tick of a running release drops both flags and stops the timer.
   a_release_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_tuser == ACTION_TICK) && run_ff && (rel_ff >= hold_ff))
      |=> (!open_ff && !alarm_ff && !run_ff))
      else $error("release did not clear the flags");

   // The entry count never rises past its saturation mark.
   a_count_capped: assert property (@(posedge clock) disable iff (reset)
      count <= ENTRY_CAP)
      else $error("entry count above its cap");

endmodule

[dv/tb.sv]
// Self-checking testbench for keypad_code_lock_controller: key and tick beats in,
// lock status beats out, each status checked against a behavioural lock model.
// Depends on kclc_pkg for widths, key codes and register indexes.
module tb;
   import kclc_pkg::*;

   localparam int QUIET_LIMIT  = 2000;
   localparam int PHASE_ITEMS  = 125;
   localparam int HOLD_OFF_LEN = 90;

   // Status word as packed on rsp_tdata, lowest field last.
   typedef struct packed {
      logic [4:0]       pad;
      logic             locked_out;
      logic             changing;
      logic [CNT_W-1:0] entered;
      logic [2:0]       failures;
      logic             alarm;
      logic             unlocked;
   } lock_status_type;

   // Ways of getting the code wrong on purpose.
   typedef enum int {SPOIL_NONE, SPOIL_DIGIT, SPOIL_SHORT, SPOIL_LONG, SPOIL_LETTER} spoil_type;

   // Lock model: tracks code, entry, failure count and release timer, and keeps
   // the status words still owed by the block.
   class lock_checker;
      logic [7:0]       hold_ticks;
      logic [2:0]       lockout_at;
      code_type         code;
      code_type         entry;
      logic [CNT_W-1:0] count;
      logic [2:0]       fails;
      bit               changing;
      int unsigned      capture;
      bit               timer_on;
      logic [7:0]       timer;
      bit               is_open;
      bit               alarm;
      lock_status_type  status_due[$];
      int unsigned      mismatches, unexpected, checked;
      int unsigned      unlocks, bad_attempts, lockouts, new_codes, releases;

      function new();
         hold_ticks = HOLD_RESET;
         lockout_at = LOCKOUT_RESET;
         for (int i = 0; i < CODE_DIGITS; i++) begin
            code[i] = RESET_DIGIT;
         end
         clear_entry();
         fails    = '0;
         changing = 1'b0;
         capture  = 0;
         timer_on = 1'b0;
         timer    = '0;
         is_open  = 1'b0;
         alarm    = 1'b0;
      endfunction

      function void clear_entry();
         for (int i = 0; i < CODE_DIGITS; i++) begin
            entry[i] = BLANK_ENTRY;
         end
         count = '0;
      endfunction

      // A lockout value of zero behaves as one.
      function bit locked_out_now();
         return fails >= ((lockout_at == 3'd0) ? 3'd1 : lockout_at);
      endfunction

      function void set_register(logic idx, logic [7:0] value);
         if (idx == CSR_HOLD) begin
            hold_ticks = value;
         end else begin
            lockout_at = value[2:0];
         end
      endfunction

      // Apply one accepted beat and queue the status it should produce.
      function void note_item(logic action, logic [3:0] key);
         bit              match;
         lock_status_type exp;
         if (action == ACTION_TICK) begin
            if (timer_on) begin
               if (timer < hold_ticks) begin
                  timer++;
               end else begin
                  timer_on = 1'b0;
                  timer    = '0;
                  is_open  = 1'b0;
                  alarm    = 1'b0;
                  releases++;
               end
            end
         end else if (key <= KEY_9 || key == KEY_B || key == KEY_F) begin
            if (count < CODE_DIGITS) entry[count] = key;
            if (count < ENTRY_CAP) count++;
            // In change mode digits are also captured into the code.
            if (changing && key <= KEY_9) begin
               if (capture < CODE_DIGITS) code[capture] = key;
               capture++;
               if (capture >= CODE_DIGITS) begin
                  capture  = 0;
                  changing = 1'b0;
                  new_codes++;
               end
            end
         end else if (key == KEY_ENTER) begin
            match = (count == CODE_DIGITS) && (entry == code);
            clear_entry();
            timer_on = 1'b1;
            timer    = '0;
            if (match) begin
               is_open = 1'b1;
               fails   = '0;
               unlocks++;
            end else begin
               is_open = 1'b0;
               alarm   = 1'b1;
               bad_attempts++;
               if (fails < FAIL_MAX) fails++;
               // Once locked out the timer stops, so the alarm stays latched.
               if (locked_out_now()) begin
                  timer_on = 1'b0;
                  lockouts++;
               end
            end
         end else if (key == KEY_CANCEL) begin
            clear_entry();
         end else if (key == KEY_CHANGE) begin
            clear_entry();
            changing = 1'b1;
            capture  = 0;
         end else begin
            clear_entry();
            changing = 1'b0;
            capture  = 0;
            timer_on = 1'b1;
            timer    = '0;
         end
         exp            = '0;
         exp.unlocked   = is_open;
         exp.alarm      = alarm;
         exp.failures   = fails;
         exp.entered    = count;
         exp.changing   = changing;
         exp.locked_out = locked_out_now();
         status_due.push_back(exp);
      endfunction

      // Compare one status beat with the oldest status owed.
      function void check_status(logic [15:0] data);
         lock_status_type got;
         lock_status_type exp;
         bit              bad;
         got = data;
         if (status_due.size() == 0) begin
            unexpected++;
            if (mismatches + unexpected <= 10)
               $display("unexpected status beat %h with nothing outstanding", data);
            return;
         end
         exp = status_due.pop_front();
         checked++;
         bad = (got.unlocked !== exp.unlocked) || (got.alarm !== exp.alarm) ||
               (got.failures !== exp.failures) || (got.entered !== exp.entered) ||
               (got.changing !== exp.changing) || (got.locked_out !== exp.locked_out) ||
               (got.pad !== exp.pad);
         if (bad) begin
            mismatches++;
            if (mismatches + unexpected <= 10) begin
               $display("status %0d expected: unlocked=%b alarm=%b failures=%0d entered=%0d",
                        checked, exp.unlocked, exp.alarm, exp.failures, exp.entered);
               $display("   changing=%b locked_out=%b pad=%h", exp.changing, exp.locked_out,
                        exp.pad);
               $display("status %0d got:      unlocked=%b alarm=%b failures=%0d entered=%0d",
                        checked, got.unlocked, got.alarm, got.failures, got.entered);
               $display("   changing=%b locked_out=%b pad=%h", got.changing, got.locked_out,
                        got.pad);
            end
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic        req_tuser  = ACTION_KEY;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_we     = 1'b0;
   logic        csr_index  = CSR_HOLD;
   logic [7:0]  csr_wdata  = '0;

   lock_checker sb = new();

   int          sent;
   int          settings = 1;
   int          quiet;
   int          burst_left;
   bit          gaps_on = 1'b1;
   int          stall_mode;
   logic [3:0]  stall_phase = '0;
   logic [15:0] stall_pattern = 16'b1011_0111_0011_1110;
   int          hold_off_asked, hold_off_served, hold_off_left;

   keypad_code_lock_controller i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // Receiver: one long hold-off on request, otherwise the stall pattern of the phase.
   always @(posedge clock) begin
      if (hold_off_left > 0) begin
         rsp_tready <= 1'b0;
         hold_off_left--;
      end else if (hold_off_served != hold_off_asked) begin
         hold_off_served++;
         hold_off_left = HOLD_OFF_LEN;
         rsp_tready <= 1'b0;
      end else begin
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: begin
               rsp_tready  <= stall_pattern[stall_phase];
               stall_phase <= stall_phase + 4'd1;
            end
            default: rsp_tready <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // Beat monitor and watchdog.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_item(req_tuser, req_tdata[3:0]);
         if (rsp_tvalid && rsp_tready) sb.check_status(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
            quiet = 0;
         end else begin
            quiet++;
         end
         if (quiet >= QUIET_LIMIT) begin
            $display("watchdog: %0d cycles without a beat, %0d statuses outstanding",
                     quiet, sb.status_due.size());
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // Offer one beat, inserting a random gap between bursts, and wait for it to go.
   task automatic send(logic action, logic [3:0] key);
      if (gaps_on && burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 16);
      end
      if (burst_left > 0) burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= {4'b0000, key};
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   task automatic press(logic [3:0] key);
      send(ACTION_KEY, key);
   endtask

   // Ticks carry a random key, which the block must ignore.
   task automatic tick_burst(int n);
      repeat (n) send(ACTION_TICK, 4'($urandom_range(0, 15)));
   endtask

   // Type the current code, possibly spoilt, then press enter.
   task automatic type_code(spoil_type spoil);
      int         slip;
      logic [3:0] d;
      slip = $urandom_range(0, CODE_DIGITS - 1);
      for (int i = 0; i < CODE_DIGITS; i++) begin
         d = sb.code[i];
         if (i == slip) begin
            case (spoil)
               SPOIL_DIGIT:  d = 4'((int'(d) + $urandom_range(1, 9)) % 10);
               SPOIL_SHORT:  continue;
               SPOIL_LONG:   press(4'($urandom_range(0, 9)));
               SPOIL_LETTER: d = ($urandom_range(0, 1) != 0) ? KEY_B : KEY_F;
               default: ;
            endcase
         end
         press(d);
      end
      press(KEY_ENTER);
   endtask

   // Enter change mode, capture digits with the odd stray key, then try the new code.
   task automatic change_code();
      int n;
      press(KEY_CHANGE);
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, CODE_DIGITS - 1) : CODE_DIGITS;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 2))
               0: press(KEY_B);
               1: press(KEY_F);
               default: press(KEY_CANCEL);
            endcase
         end
         press(4'($urandom_range(0, 9)));
      end
      if (n < CODE_DIGITS || $urandom_range(0, 1) != 0) press(KEY_CONFIRM);
      type_code(SPOIL_NONE);
   endtask

   // Let every outstanding status drain before touching the registers.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.status_due.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_regs(logic [7:0] hold, logic [2:0] lockout);
      logic [7:0] word;
      word = {5'($urandom), lockout};
      csr_we    <= 1'b1;
      csr_index <= CSR_HOLD;
      csr_wdata <= hold;
      @(posedge clock);
      sb.set_register(CSR_HOLD, hold);
      csr_index <= CSR_LOCKOUT;
      csr_wdata <= word;
      @(posedge clock);
      sb.set_register(CSR_LOCKOUT, word);
      csr_we <= 1'b0;
      settings++;
   endtask

   initial begin
      int        phase;
      int        r;
      int        start;
      int        len;
      spoil_type spoil;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: idle tick, default code, overflow, change mode ending by itself,
      // every command and letter key, extreme digits.
      send(ACTION_TICK, KEY_F);
      repeat (CODE_DIGITS) press(RESET_DIGIT);
      press(KEY_ENTER);
      send(ACTION_TICK, KEY_0);
      press(KEY_CHANGE);
      press(KEY_0);
      press(KEY_9);
      for (int d = 1; d <= 5; d++) press(4'(d));
      press(KEY_9);
      press(4'd7);
      press(KEY_B);
      press(KEY_ENTER);
      press(KEY_F);
      press(KEY_CANCEL);
      press(KEY_CHANGE);
      press(KEY_CONFIRM);

      // Random phases, each under its own register setting and receiver behaviour.
      for (phase = 0; phase < 5; phase++) begin
         if (phase > 0) begin
            wait_idle();
            case (phase)
               1: write_regs(8'd0, 3'd1);
               2: write_regs(8'd255, 3'd7);
               3: write_regs(8'd4, 3'd0);
               default: write_regs(8'($urandom_range(1, 12)), 3'($urandom_range(2, 6)));
            endcase
         end
         stall_mode = phase % 3;
         gaps_on    = (phase != 2);
         if (phase == 4) begin
            // Keep offering beats while the receiver holds off.
            hold_off_asked++;
            gaps_on = 1'b0;
         end
         start = sent;
         while (sent - start < PHASE_ITEMS) begin
            if (phase == 4 && sent - start >= 40) gaps_on = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 45) begin
               spoil = SPOIL_NONE;
               if ($urandom_range(0, 9) < ((phase == 2) ? 8 : 4))
                  spoil = spoil_type'($urandom_range(SPOIL_DIGIT, SPOIL_LETTER));
               type_code(spoil);
            end else if (r < 60) begin
               change_code();
            end else if (r < 80) begin
               if ($urandom_range(0, 3) == 0 && sb.hold_ticks <= 24) begin
                  len = sb.hold_ticks + 2;
               end else begin
                  len = $urandom_range(1, 6);
               end
               tick_burst(len);
            end else begin
               repeat ($urandom_range(1, 4))
                  send(($urandom_range(0, 3) == 0) ? ACTION_TICK : ACTION_KEY,
                       4'($urandom_range(0, 15)));
            end
         end
      end

      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.status_due.size() != 0);
      repeat (4) @(posedge clock);

      $display("Ran %0d beats under %0d register settings, %0d statuses checked.",
               sent, settings, sb.checked);
      $display("Seen: %0d unlocks, %0d failed attempts, %0d lockouts, %0d new codes, %0d releases.",
               sb.unlocks, sb.bad_attempts, sb.lockouts, sb.new_codes, sb.releases);
      if (sb.mismatches + sb.unexpected + sb.status_due.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatches, %0d unexpected, %0d missing", sb.mismatches,
                  sb.unexpected, sb.status_due.size());
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

[keypad_code_lock_controller.f]
hdl/kclc_pkg.sv
hdl/kclc_entry.sv
hdl/keypad_code_lock_controller.sv
dv/tb.sv
